[rtl/core/ncprof_pkg.sv]
// ncprof_pkg: shared types and constants of the nested category time profiler
`default_nettype none
package ncprof_pkg;
  localparam int NumSlots   = 16;
  localparam int StackDepth = 16;
  localparam int RingFrames = 256;
  localparam int SlotW  = 4;
  localparam int DepthW = 4;
  localparam int RingW  = 8;
  localparam int HistW  = RingW + SlotW;
  localparam int HistDepth = RingFrames * NumSlots;
  localparam int UsedW  = 5;

  localparam logic [2:0] FuncEnter = 3'd0;
  localparam logic [2:0] FuncLeave = 3'd1;
  localparam logic [2:0] FuncEnd   = 3'd2;
  localparam logic [2:0] FuncRdHist = 3'd3;
  localparam logic [2:0] FuncRdKey = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] name_key;
    logic [3:0]  slot;
    logic        slot_valid;
    logic [31:0] now_ticks;
    logic [7:0]  history_index;
    logic [8:0]  span;
  } req_t;

  typedef struct packed {
    logic [3:0]  category_slot;
    logic        category_found;
    logic [31:0] frame_time;
    logic [31:0] frame_count;
    logic [31:0] slot_key;
    logic [4:0]  categories_used;
    logic        nesting_error;
  } res_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage
`default_nettype wire

[rtl/core/ncprof_ram.sv]
// ncprof_ram: generic single port ram with registered read
`default_nettype none
module ncprof_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/core/ncprof_front.sv]
// ncprof_front: request intake and two-entry queue to the back end
`default_nettype none
module ncprof_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  wire ncprof_pkg::req_t in_req,
  output logic      q_valid,
  output ncprof_pkg::req_t q_req,
  input  wire logic q_take
);
  import ncprof_pkg::*;
  req_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  assign in_full = (cnt_r == 2'd2);
  assign do_push = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= in_req;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (q_take) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, q_take};
    end
  end
endmodule
`default_nettype wire

[rtl/core/ncprof_back.sv]
// ncprof_back: sequencer that carries out profiler requests on the state
`default_nettype none
module ncprof_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire ncprof_pkg::req_t q_req,
  output logic      q_take,
  output logic      res_valid,
  output ncprof_pkg::res_t res,
  input  wire logic res_taken
);
  import ncprof_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_PRD, S_PWAIT, S_PWR, S_LRD, S_LWAIT, S_LWR, S_EWR,
    S_HRD, S_HWAIT, S_RES
  } state_t;

  state_t state_r;
  req_t req_r;
  res_t res_r;
  logic [31:0] keys_r  [NumSlots];
  logic [31:0] start_r [NumSlots];
  logic [SlotW-1:0] stack_r [StackDepth];
  logic [DepthW-1:0] depth_r;
  logic [RingW-1:0] ring_r;
  logic [HistW-1:0] clr_r;
  logic [SlotW-1:0] eslot_r;
  logic [SlotW-1:0] pslot_r;
  logic [SlotW:0] fi;
  logic           fhit;

  logic we;
  logic [HistW-1:0] addr;
  logic [31:0] wt, wc, rt, rc;

  ncprof_ram #(.Width(32), .Depth(HistDepth)) u_time (
    .clk(clk), .we(we), .addr(addr), .wdata(wt), .rdata(rt));
  ncprof_ram #(.Width(32), .Depth(HistDepth)) u_cnt (
    .clk(clk), .we(we), .addr(addr), .wdata(wc), .rdata(rc));

  logic [UsedW-1:0] used;
  always_comb begin
    used = UsedW'(NumSlots);
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (keys_r[i] == 32'd0) begin
        used = UsedW'(i);
      end
    end
  end

  // first match or first free slot
  always_comb begin
    fi = (SlotW + 1)'(NumSlots);
    fhit = 1'b0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (keys_r[i] == 32'd0 || keys_r[i] == req_r.name_key) begin
        fi = (SlotW + 1)'(i);
        fhit = (keys_r[i] != 32'd0);
      end
    end
  end

  logic [RingW:0] frame_sum;
  assign frame_sum = (RingW + 1)'({1'b0, req_r.history_index} - req_r.span
                     + {1'b0, ring_r} + 9'd1);
  logic [RingW-1:0] frame;
  assign frame = frame_sum[RingW-1:0];

  always_comb begin
    we = 1'b0;
    wt = rt;
    wc = rc;
    addr = {ring_r, req_r.slot};
    case (state_r)
      S_CLEAR: begin
        we = 1'b1; addr = clr_r; wt = 32'd0; wc = 32'd0;
      end
      S_PRD, S_PWAIT: addr = {ring_r, pslot_r};
      S_PWR: begin
        addr = {ring_r, pslot_r}; we = 1'b1;
        // a parent re-entered by this request had no start before it
        wt = sat_add(rt, req_r.now_ticks -
                     ((pslot_r == eslot_r) ? 32'd0 : start_r[pslot_r]));
      end
      S_LWR: begin
        we = 1'b1;
        wt = sat_add(rt, req_r.now_ticks - start_r[req_r.slot]);
        wc = sat_add(rc, 32'd1);
      end
      S_EWR: begin
        we = 1'b1; addr = clr_r; wt = 32'd0; wc = 32'd0;
      end
      S_HRD, S_HWAIT: addr = {frame, req_r.slot};
      default: ;
    endcase
  end

  assign q_take = (state_r == S_IDLE) && q_valid;
  assign res_valid = (state_r == S_RES);

  always_comb begin
    res = res_r;
    res.categories_used = used;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      depth_r <= '0;
      ring_r <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        keys_r[i] <= 32'd0;
        start_r[i] <= 32'd0;
      end
      for (int i = 0; i < StackDepth; i++) begin
        stack_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == HistW'(HistDepth - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            req_r <= q_req;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          res_r <= '0;
          state_r <= S_RES;
          case (req_r.func)
            FuncEnter: begin
              if (req_r.name_key != 32'd0 && (fhit || fi < (SlotW + 1)'(NumSlots))) begin
                eslot_r <= fi[SlotW-1:0];
                res_r.category_slot <= fi[SlotW-1:0];
                res_r.category_found <= 1'b1;
                if (!fhit) begin
                  keys_r[fi[SlotW-1:0]] <= req_r.name_key;
                end
                if (start_r[fi[SlotW-1:0]] == 32'd0) begin
                  if (depth_r == DepthW'(StackDepth - 1)) begin
                    res_r.nesting_error <= 1'b1;
                  end else begin
                    pslot_r <= stack_r[depth_r];
                    start_r[fi[SlotW-1:0]] <= req_r.now_ticks;
                    depth_r <= depth_r + 1'b1;
                    stack_r[depth_r + 1'b1] <= fi[SlotW-1:0];
                    if (stack_r[depth_r] != '0) begin
                      state_r <= S_PRD;
                    end
                  end
                end
              end
            end
            FuncLeave: begin
              if (req_r.slot_valid) begin
                state_r <= S_LRD;
              end
            end
            FuncEnd: begin
              ring_r <= ring_r + 1'b1;
              clr_r <= {ring_r + 1'b1, {SlotW{1'b0}}};
              state_r <= S_EWR;
            end
            FuncRdHist: begin
              res_r.category_slot <= req_r.slot;
              res_r.category_found <= 1'b1;
              state_r <= S_HRD;
            end
            FuncRdKey: begin
              res_r.category_slot <= req_r.slot;
              res_r.category_found <= 1'b1;
              res_r.slot_key <= keys_r[req_r.slot];
            end
            default: ;
          endcase
        end
        S_PRD: state_r <= S_PWAIT;
        S_PWAIT: state_r <= S_PWR;
        S_PWR: begin
          // a re-entered parent keeps the start set by this enter
          if (pslot_r != eslot_r) begin
            start_r[pslot_r] <= 32'd0;
          end
          state_r <= S_RES;
        end
        S_LRD: state_r <= S_LWAIT;
        S_LWAIT: state_r <= S_LWR;
        S_LWR: begin
          start_r[req_r.slot] <= 32'd0;
          if (depth_r == '0) begin
            res_r.nesting_error <= 1'b1;
          end else begin
            depth_r <= depth_r - 1'b1;
            if (stack_r[depth_r - 1'b1] != '0) begin
              start_r[stack_r[depth_r - 1'b1]] <= req_r.now_ticks;
            end
          end
          state_r <= S_RES;
        end
        S_EWR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r[SlotW-1:0] == SlotW'(NumSlots - 1)) begin
            state_r <= S_RES;
          end
        end
        S_HRD: state_r <= S_HWAIT;
        S_HWAIT: begin
          res_r.frame_time <= rt;
          res_r.frame_count <= rc;
          state_r <= S_RES;
        end
        S_RES: begin
          if (res_taken) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/nested_category_time_profiler.sv]
// nested_category_time_profiler: top level of the nested category time profiler
`default_nettype none
// Hierarchical exclusive-time profiler. Requests enter a two-entry queue and are
// executed one at a time by a sequencer; each request gives exactly one result,
// held in a one-entry output register. Enter and leave do at most one
// read-modify-write of the history ram, and end frame clears the new row one slot
// at a time. After reset the history ram (4096 entries) is cleared one entry a
// cycle; no request is taken until the clear is done.
module nested_category_time_profiler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [2:0]  in_func,
  input  wire logic [31:0] in_name_key,
  input  wire logic [3:0]  in_slot,
  input  wire logic        in_slot_valid,
  input  wire logic [31:0] in_now_ticks,
  input  wire logic [7:0]  in_history_index,
  input  wire logic [8:0]  in_span,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [3:0]       out_category_slot,
  output logic             out_category_found,
  output logic [31:0]      out_frame_time,
  output logic [31:0]      out_frame_count,
  output logic [31:0]      out_slot_key,
  output logic [4:0]       out_categories_used,
  output logic             out_nesting_error
);
  import ncprof_pkg::*;
  req_t in_req, q_req;
  res_t res;
  logic q_valid, q_take, res_valid, full_w;
  assign in_req = '{in_func, in_name_key, in_slot, in_slot_valid, in_now_ticks,
                    in_history_index, in_span};
  ncprof_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(full_w), .in_req(in_req),
    .q_valid(q_valid), .q_req(q_req), .q_take(q_take));
  assign in_full = full_w;
  ncprof_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req), .q_take(q_take),
    .res_valid(res_valid), .res(res), .res_taken(out_pop));
  assign out_empty = !res_valid;
  assign out_category_slot = res.category_slot;
  assign out_category_found = res.category_found;
  assign out_frame_time = res.frame_time;
  assign out_frame_count = res.frame_count;
  assign out_slot_key = res.slot_key;
  assign out_categories_used = res.categories_used;
  assign out_nesting_error = res.nesting_error;
endmodule
`default_nettype wire

[rtl/core/ncprof_checker.sv]
// ncprof_checker: port level assertions for the profiler
`default_nettype none
module ncprof_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_empty,
  input wire logic out_pop,
  input wire logic out_category_found,
  input wire logic [4:0] out_categories_used,
  input wire logic [31:0] out_slot_key
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty) else $error("result dropped");
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_categories_used <= 5'd16) else $error("used range");
  a_key: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_slot_key != 32'd0 |-> out_category_found)
    else $error("key without slot");
endmodule
bind nested_category_time_profiler ncprof_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_empty(out_empty), .out_pop(out_pop),
  .out_category_found(out_category_found), .out_categories_used(out_categories_used),
  .out_slot_key(out_slot_key));
`default_nettype wire

[verif/ncprof_checker.sv]
// ncprof_scoreboard: predicts profiler results from accepted requests and compares them
`timescale 1ns / 100ps
module ncprof_scoreboard (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic        in_full,
  input  wire logic [2:0]  in_func,
  input  wire logic [31:0] in_name_key,
  input  wire logic [3:0]  in_slot,
  input  wire logic        in_slot_valid,
  input  wire logic [31:0] in_now_ticks,
  input  wire logic [7:0]  in_history_index,
  input  wire logic [8:0]  in_span,
  input  wire logic        out_empty,
  input  wire logic        out_pop,
  input  wire logic [3:0]  out_category_slot,
  input  wire logic        out_category_found,
  input  wire logic [31:0] out_frame_time,
  input  wire logic [31:0] out_frame_count,
  input  wire logic [31:0] out_slot_key,
  input  wire logic [4:0]  out_categories_used,
  input  wire logic        out_nesting_error,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);
  import ncprof_pkg::*;

  logic [31:0] key_tbl [NumSlots];
  logic [31:0] started_at [NumSlots];
  logic [SlotW-1:0] parents [StackDepth];
  int unsigned depth;
  logic [RingW-1:0] frame_pos;
  logic [31:0] acc_time [HistDepth];
  logic [31:0] acc_count [HistDepth];
  res_t expected_results [$];

  function automatic logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int occupied();
    int i;
    for (i = 0; i < NumSlots; i++) if (key_tbl[i] == 0) break;
    return i;
  endfunction

  task automatic suspend(int s, logic [31:0] now);
    int c;
    c = int'(frame_pos) * NumSlots + s;
    acc_time[c] = clamp_add(acc_time[c], now - started_at[s]);
    started_at[s] = 32'd0;
  endtask

  task automatic profile_step(req_t q);
    res_t r;
    int i, c, fr;
    bit hit;
    r = '0;
    hit = 0;
    case (q.func)
      FuncEnter: begin
        for (i = 0; i < NumSlots; i++) begin
          if (key_tbl[i] == 0) break;
          if (key_tbl[i] == q.name_key) begin
            hit = 1;
            break;
          end
        end
        if (!hit && i < NumSlots && q.name_key != 0) begin
          key_tbl[i] = q.name_key;
          hit = 1;
        end
        if (hit) begin
          r.category_slot = i[3:0];
          r.category_found = 1'b1;
          if (started_at[i] == 0) begin
            if (depth + 1 >= StackDepth) r.nesting_error = 1'b1;
            else begin
              if (parents[depth] != 0) suspend(int'(parents[depth]), q.now_ticks);
              started_at[i] = q.now_ticks;
              depth++;
              parents[depth] = i[3:0];
            end
          end
        end
      end
      FuncLeave: begin
        if (q.slot_valid) begin
          c = int'(frame_pos) * NumSlots + int'(q.slot);
          suspend(int'(q.slot), q.now_ticks);
          acc_count[c] = clamp_add(acc_count[c], 32'd1);
          if (depth == 0) r.nesting_error = 1'b1;
          else begin
            depth--;
            if (parents[depth] != 0) started_at[parents[depth]] = q.now_ticks;
          end
        end
      end
      FuncEnd: begin
        frame_pos = frame_pos + 1'b1;
        for (i = 0; i < NumSlots; i++) begin
          acc_time[int'(frame_pos) * NumSlots + i] = 32'd0;
          acc_count[int'(frame_pos) * NumSlots + i] = 32'd0;
        end
      end
      FuncRdHist: begin
        r.category_slot = q.slot;
        r.category_found = 1'b1;
        fr = (int'(q.history_index) - int'(q.span) + int'(frame_pos) + 1) % RingFrames;
        if (fr < 0) fr += RingFrames;
        r.frame_time = acc_time[fr * NumSlots + int'(q.slot)];
        r.frame_count = acc_count[fr * NumSlots + int'(q.slot)];
      end
      FuncRdKey: begin
        r.category_slot = q.slot;
        r.category_found = 1'b1;
        r.slot_key = key_tbl[q.slot];
      end
      default: ;
    endcase
    r.categories_used = 5'(occupied());
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      foreach (key_tbl[i]) begin
        key_tbl[i] <= 0;
        started_at[i] <= 0;
      end
      foreach (parents[i]) parents[i] <= '0;
      foreach (acc_time[i]) begin
        acc_time[i] <= 0;
        acc_count[i] <= 0;
      end
      depth <= 0;
      frame_pos <= '0;
      fail_count <= 0;
      result_count <= 0;
      expected_results.delete();
    end else begin
      if (out_pop && !out_empty) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $error("result with no request waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (e.category_slot !== out_category_slot ||
              e.category_found !== out_category_found ||
              e.frame_time !== out_frame_time || e.frame_count !== out_frame_count ||
              e.slot_key !== out_slot_key ||
              e.categories_used !== out_categories_used ||
              e.nesting_error !== out_nesting_error) begin
            fail_count <= fail_count + 1;
            if (e.category_slot !== out_category_slot)
              $error("category_slot exp %0d got %0d", e.category_slot, out_category_slot);
            if (e.category_found !== out_category_found)
              $error("category_found exp %0d got %0d", e.category_found,
                     out_category_found);
            if (e.frame_time !== out_frame_time)
              $error("frame_time exp %0h got %0h", e.frame_time, out_frame_time);
            if (e.frame_count !== out_frame_count)
              $error("frame_count exp %0h got %0h", e.frame_count, out_frame_count);
            if (e.slot_key !== out_slot_key)
              $error("slot_key exp %0h got %0h", e.slot_key, out_slot_key);
            if (e.categories_used !== out_categories_used)
              $error("categories_used exp %0d got %0d", e.categories_used,
                     out_categories_used);
            if (e.nesting_error !== out_nesting_error)
              $error("nesting_error exp %0d got %0d", e.nesting_error, out_nesting_error);
          end
        end
      end
      if (in_push && !in_full)
        profile_step('{in_func, in_name_key, in_slot, in_slot_valid, in_now_ticks,
                       in_history_index, in_span});
    end
    pending_count <= expected_results.size();
  end
endmodule

[verif/tb_nested_category_time_profiler.sv]
// tb_nested_category_time_profiler: stimulus and verdict for the category time profiler
`timescale 1ns / 100ps
module tb_nested_category_time_profiler;
  import ncprof_pkg::*;

  localparam int LimitCycles = 600000;

  logic clk, rst_n;
  logic in_push, in_full, out_empty, out_pop;
  logic [2:0] in_func;
  logic [31:0] in_name_key, in_now_ticks;
  logic [3:0] in_slot;
  logic in_slot_valid;
  logic [7:0] in_history_index;
  logic [8:0] in_span;
  logic [3:0] out_category_slot;
  logic out_category_found, out_nesting_error;
  logic [31:0] out_frame_time, out_frame_count, out_slot_key;
  logic [4:0] out_categories_used;
  int fail_count, pending_count, result_count;
  int cycle_count, request_count;
  bit hold_off;
  logic [31:0] clock_ticks;
  logic [31:0] key_pool [24];

  nested_category_time_profiler u_top (.*);
  ncprof_scoreboard u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int w;
    out_pop = 0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_pop <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        out_pop <= 0;
        repeat (w) @(posedge clk);
      end
      out_pop <= 1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  task automatic send(logic [2:0] f, logic [31:0] k, logic [3:0] s, logic v,
                      logic [31:0] t, logic [7:0] h, logic [8:0] sp);
    in_push <= 1;
    in_func <= f;
    in_name_key <= k;
    in_slot <= s;
    in_slot_valid <= v;
    in_now_ticks <= t;
    in_history_index <= h;
    in_span <= sp;
    @(posedge clk);
    while (in_full) @(posedge clk);
    request_count++;
  endtask

  task automatic gap();
    int w;
    w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (w > 0) begin
      in_push <= 0;
      repeat (w) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] tick();
    clock_ticks = clock_ticks + $urandom_range(1, 5000);
    if (clock_ticks == 0) clock_ticks = 1;
    return clock_ticks;
  endfunction

  initial begin
    int i, n, sel;
    cycle_count = 0;
    request_count = 0;
    hold_off = 0;
    clock_ticks = 1;
    rst_n = 0;
    in_push = 0;
    in_func = FuncEnter;
    in_name_key = 0;
    in_slot = 0;
    in_slot_valid = 0;
    in_now_ticks = 1;
    in_history_index = 0;
    in_span = 0;
    foreach (key_pool[k]) key_pool[k] = $urandom() | 32'h1;
    key_pool[0] = 32'hFFFF_FFFF;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // directed
    send(FuncEnter, 0, 0, 0, 32'h10, 0, 0);
    send(FuncLeave, 0, 0, 1, 32'h20, 0, 0);
    send(FuncEnter, key_pool[0], 0, 0, 32'hFFFF_FFF0, 0, 0);
    send(FuncEnter, key_pool[0], 0, 0, 32'hFFFF_FFF8, 0, 0);
    send(FuncEnter, key_pool[1], 0, 0, 32'hFFFF_FFFF, 0, 0);
    send(FuncLeave, 0, 1, 1, 32'h5, 0, 0);
    send(FuncLeave, 0, 0, 1, 32'h9, 0, 0);
    send(FuncLeave, 0, 3, 0, 32'h9, 0, 0);
    send(FuncLeave, 0, 2, 1, 32'hFFFF_FFFF, 0, 0);
    send(FuncRdHist, 0, 0, 0, 1, 8'hFF, 9'd256);
    send(FuncRdHist, 0, 2, 1, 1, 0, 0);
    send(FuncRdHist, 0, 15, 0, 1, 8'hFF, 9'h1FF);
    send(FuncRdKey, 0, 0, 0, 1, 0, 0);
    send(FuncRdKey, 0, 15, 0, 1, 0, 0);
    send(FuncEnd, 0, 0, 0, 1, 0, 0);
    send(3'd5, 32'hFFFF_FFFF, 15, 1, 32'hFFFF_FFFF, 8'hFF, 9'h1FF);
    send(3'd7, 0, 0, 0, 1, 0, 0);
    // fill table and overflow the stack
    for (i = 2; i < 20; i++) send(FuncEnter, key_pool[i], 0, 0, tick(), 0, 0);
    send(FuncRdKey, 0, 15, 0, 1, 0, 0);
    hold_off = 1;
    for (i = 0; i < 20; i++) send(FuncLeave, 0, i[3:0], 1, tick(), 0, 0);
    in_push <= 0;
    @(posedge clk);
    while (pending_count > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    // random, mostly balanced nesting over a full table
    for (n = 0; n < 2000; n++) begin
      gap();
      sel = $urandom_range(0, 99);
      if (sel < 30)
        send(FuncEnter, ($urandom_range(0, 40) == 0) ? $urandom() :
             key_pool[$urandom_range(0, 19)], 4'($urandom()), 1'($urandom()), tick(),
             8'($urandom()), 9'($urandom()));
      else if (sel < 60)
        send(FuncLeave, $urandom(), 4'($urandom()), $urandom_range(0, 9) != 0, tick(),
             8'($urandom()), 9'($urandom()));
      else if (sel < 66)
        send(FuncEnd, $urandom(), 4'($urandom()), 1'($urandom()), tick(),
             8'($urandom()), 9'($urandom()));
      else if (sel < 86)
        send(FuncRdHist, $urandom(), 4'($urandom()), 1'($urandom()), tick(),
             8'($urandom()),
             $urandom_range(0, 1) ? 9'($urandom_range(0, 256)) : 9'($urandom_range(0, 511)));
      else if (sel < 96)
        send(FuncRdKey, $urandom(), 4'($urandom()), 1'($urandom()), tick(),
             8'($urandom()), 9'($urandom()));
      else
        send(3'($urandom_range(5, 7)), $urandom(), 4'($urandom()), 1'($urandom()),
             $urandom(), 8'($urandom()), 9'($urandom()));
    end
    in_push <= 0;
    @(posedge clk);
    while (pending_count > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d requests, checked %0d results", request_count, result_count);
    $display("covered enter/leave nesting, overflow, frame ends and history reads");
    if (fail_count == 0 && pending_count == 0 && result_count == request_count) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
